/* design/assert_macros.svh */
// Assertion macros for the block allocator checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define BCBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

/* design/bcba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
// No dependencies.
package bcba_pkg;

  localparam int unsigned Blocks = 64;
  localparam int unsigned PosW   = $clog2(Blocks);
  localparam int unsigned CntW   = $clog2(Blocks + 1);

  typedef enum logic {
    FuncAlloc = 1'b0,
    FuncFree  = 1'b1
  } func_e;

  typedef enum logic {
    PolicyFirstFit = 1'b0,
    PolicyNextFit  = 1'b1
  } policy_e;

  typedef struct packed {
    func_e       func;
    policy_e     alloc_policy;
    logic [6:0]  request_size;
    logic [5:0]  free_start;
    logic [6:0]  free_length;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [5:0]  start_block;
    logic [6:0]  allocated_count;
  } resp_t;

endpackage

/* design/bcba_cell.sv */
// One bitmap cell of the allocator's rotating ring.
// No dependencies.
module bcba_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic bit_i,
  output logic bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule

/* design/bitmap_contiguous_block_allocator.sv */
// Bitmap first/next-fit allocator: a free and a failed first-fit allocate take one pass
// of the bitmap ring, a placed first-fit allocate a scan pass and a mark pass, and next
// fit up to two scan passes and a mark pass; every operation then ends in StDone.
// One item at a time; the next transfer can be accepted in the cycle after the result
// is registered, also while that result still waits.
// Reset (rst_ni low, async): every block free, pointer and count zero, output empty.
module bitmap_contiguous_block_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bcba_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bcba_pkg::resp_t out_data_o
);
  import bcba_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,   // search pass, bitmap unchanged
    StMark,   // write pass, sets the found run
    StFree,   // write pass, clears the requested run
    StDone    // result waits for the output register
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [PosW-1:0]   pos_q;      // block index now at the ring head
  logic              pass_b_q;   // next-fit second pass (wrapped to block 0)
  logic [CntW-1:0]   run_q;      // free blocks seen in a row
  logic              found_q;
  logic [PosW-1:0]   start_q;
  logic [PosW-1:0]   origin_q;
  logic [PosW-1:0]   ptr_q;      // next-fit pointer
  logic [CntW-1:0]   used_q;
  logic              success_q;
  logic              out_valid_q;
  resp_t             out_data_q;

  // Ring of cells: each cycle of a pass the bitmap moves one cell toward the
  // head; the head bit re-enters at the tail, possibly modified.
  logic [Blocks:0]   chain;
  logic              head;
  logic              shift_en;

  assign head     = chain[0];
  assign shift_en = (state_q == StScan) || (state_q == StMark) || (state_q == StFree);

  for (genvar i = 0; i < Blocks; i++) begin : g_cell
    bcba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_en),
      .bit_i   (chain[i+1]),
      .bit_o   (chain[i])
    );
  end

  logic            last_pos;
  logic            in_scope;
  logic [CntW-1:0] run_d;
  logic            hit;
  logic [6:0]      hit_start;
  logic [6:0]      mark_off;
  logic            mark_hit;
  logic [6:0]      free_off;
  logic            free_hit;
  logic [6:0]      ptr_sum;
  logic [PosW-1:0] ptr_d;
  logic            tail_d;

  assign last_pos = (pos_q == PosW'(Blocks - 1));

  // Pass A of next fit only counts starts at or after the pointer.
  assign in_scope = pass_b_q || (pos_q >= origin_q);
  assign run_d    = (in_scope && !head) ? run_q + CntW'(1) : '0;

  // A run reaching the requested length ends here; earliest end is earliest start.
  assign hit       = !found_q && (req_q.request_size != '0) && (run_d == req_q.request_size);
  assign hit_start = {1'b0, pos_q} + 7'd1 - req_q.request_size;

  assign mark_off = {1'b0, pos_q} - {1'b0, start_q};
  assign mark_hit = (pos_q >= start_q) && (mark_off < req_q.request_size);

  // Clipping at the last block falls out of the pass ending there.
  assign free_off = {1'b0, pos_q} - {1'b0, req_q.free_start};
  assign free_hit = (pos_q >= req_q.free_start) && (free_off < req_q.free_length);

  assign ptr_sum = {1'b0, start_q} + req_q.request_size;
  assign ptr_d   = (ptr_sum >= 7'(Blocks)) ? '0 : ptr_sum[PosW-1:0];

  always_comb begin
    case (state_q)
      StMark:  tail_d = head | mark_hit;
      StFree:  tail_d = head & ~free_hit;
      default: tail_d = head;
    endcase
  end

  assign chain[Blocks] = tail_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      pos_q       <= '0;
      pass_b_q    <= 1'b0;
      run_q       <= '0;
      found_q     <= 1'b0;
      start_q     <= '0;
      origin_q    <= '0;
      ptr_q       <= '0;
      used_q      <= '0;
      success_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // StDone refills the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            req_q    <= in_data_i;
            pos_q    <= '0;
            pass_b_q <= 1'b0;
            run_q    <= '0;
            found_q  <= 1'b0;
            start_q  <= '0;
            origin_q <= (in_data_i.alloc_policy == PolicyNextFit) ? ptr_q : '0;
            state_q  <= (in_data_i.func == FuncFree) ? StFree : StScan;
          end
        end
        StScan: begin
          pos_q <= last_pos ? '0 : pos_q + PosW'(1);
          run_q <= last_pos ? '0 : run_d;
          if (hit) begin
            found_q <= 1'b1;
            start_q <= hit_start[PosW-1:0];
          end
          if (last_pos) begin
            if (found_q || hit) begin
              state_q <= StMark;
            end else if (!pass_b_q && (origin_q != '0)) begin
              pass_b_q <= 1'b1;
            end else begin
              success_q <= 1'b0;
              start_q   <= '0;
              state_q   <= StDone;
            end
          end
        end
        StMark: begin
          pos_q <= last_pos ? '0 : pos_q + PosW'(1);
          if (last_pos) begin
            used_q    <= used_q + req_q.request_size;
            ptr_q     <= ptr_d;
            success_q <= 1'b1;
            state_q   <= StDone;
          end
        end
        StFree: begin
          pos_q <= last_pos ? '0 : pos_q + PosW'(1);
          if (head && free_hit) begin
            used_q <= used_q - CntW'(1);
          end
          if (last_pos) begin
            success_q <= 1'b1;
            start_q   <= '0;
            state_q   <= StDone;
          end
        end
        StDone: begin
          // Output register is free or being emptied this cycle.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q                <= 1'b1;
            out_data_q.success         <= success_q;
            out_data_q.start_block     <= start_q;
            out_data_q.allocated_count <= used_q;
            state_q                    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/bcba_checker.sv */
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bcba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcba_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input bcba_pkg::req_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input bcba_pkg::resp_t out_data_o
);
  import bcba_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  `BCBA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `BCBA_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall_o)
  `BCBA_ASSERT_IMP(a_fail_start_zero, out_valid_o && !out_data_o.success, out_data_o.start_block == '0)
  `BCBA_ASSERT_IMP(a_count_range, out_valid_o, out_data_o.allocated_count <= 7'(Blocks))

endmodule

bind bitmap_contiguous_block_allocator bcba_checker u_checker (.*);
